>>> src/prq_pkg.sv
// Shared types, codes and default sizes for the priority ready queue scheduler.
package prq_pkg;

  localparam int unsigned NUM_LEVELS_DEF  = 8;
  localparam int unsigned QUEUE_DEPTH_DEF = 8;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_SWITCH  = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PUSH_RUN,
    ST_POP,
    ST_DONE
  } prq_state_e;

  typedef struct packed {
    logic       op;
    logic [7:0] task_id;
    logic [2:0] priority_req;
  } prq_in_t;

  typedef struct packed {
    logic [7:0] run_task;
    logic [2:0] run_priority;
    logic       preempt;
    logic [1:0] status;
  } prq_out_t;

endpackage

>>> src/prq_entry_ram.sv
// Single-port task entry memory with a registered read.
module prq_entry_ram #(
  parameter int unsigned RAM_DEPTH = prq_pkg::NUM_LEVELS_DEF * prq_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned AddrW = $clog2(RAM_DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [RAM_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/priority_ready_queue_scheduler.sv
// Top level: multilevel FIFO ready queue with a running task register.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+---------------------------------
//   in      | input     | in_valid_i/in_stall_o | op, task_id, priority_req
//   out     | output    | out_valid_o/out_stall_i | run_task, run_priority, preempt, status
//   cfg     | input     | cfg_valid_i/cfg_ready_o | search_start
//
// One word is worked on at a time. A plain enqueue goes through update and done, a
// preempting enqueue also push-run, a switch update, pop and done, and a rejected word
// only done; the registered pointer read and the single-port entry memory set this order.
// After reset every queue is empty and the idle task runs at the lowest used level;
// pointer entries carry valid bits, so there is no clearing pass.
// A stalled result waits in the output register; the next word is taken meanwhile.
module priority_ready_queue_scheduler #(
  parameter int unsigned NUM_LEVELS  = prq_pkg::NUM_LEVELS_DEF,
  parameter int unsigned QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  prq_pkg::prq_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output prq_pkg::prq_out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_data_i
);

  localparam int unsigned LevelsUsed = (NUM_LEVELS < 8) ? NUM_LEVELS : 8;
  localparam int unsigned LW         = $clog2(NUM_LEVELS);
  localparam int unsigned PW         = $clog2(QUEUE_DEPTH);
  localparam int unsigned RamDepth   = NUM_LEVELS * QUEUE_DEPTH;
  localparam int unsigned AW         = $clog2(RamDepth);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] entry_addr(input logic [LW-1:0] lvl,
                                               input logic [PW-1:0] p);
    logic [AW-1:0] a;
    a = AW'(lvl) * AW'(QUEUE_DEPTH) + AW'(p);
    return a;
  endfunction

  prq_pkg::prq_state_e state_q, state_d;

  logic [2:0]          search_start_q;
  logic [7:0]          run_task_q;
  logic [2:0]          run_lvl_q;
  logic                cur_op_q;
  logic [2:0]          cur_lvl_q;
  logic [7:0]          cur_id_q;
  logic                higher_q;
  logic [1:0]          status_q;
  logic [NUM_LEVELS-1:0] nonempty_q;
  logic [NUM_LEVELS-1:0] full_q;
  logic [NUM_LEVELS-1:0] ptr_vld_q;
  logic [2*PW-1:0]     ptr_mem [NUM_LEVELS];
  logic [2*PW-1:0]     rd_a_q, rd_b_q;
  logic                vld_a_q, vld_b_q;
  logic                out_valid_q;
  prq_pkg::prq_out_t   out_data_q;

  // Accept-time decode.
  logic          in_acc;
  logic [2:0]    lv_sat;
  logic [LW-1:0] lv_idx, run_idx, cur_idx, tgt_idx;
  logic          higher;
  logic          enq_full;
  logic          scan_found;
  logic [2:0]    scan_lvl;
  logic [2:0]    tgt_lvl;
  logic [1:0]    acc_status;

  // Datapath controls from the sequencer.
  logic            ptr_we;
  logic [LW-1:0]   ptr_waddr;
  logic [2*PW-1:0] ptr_wdata;
  logic            flag_ne, flag_full;
  logic            st_we, st_re;
  logic [AW-1:0]   st_addr;
  logic [7:0]      st_wdata, st_rdata;
  logic            out_load;

  logic [PW-1:0] head_a, tail_a, head_b, tail_b;

  assign in_stall_o  = (state_q != prq_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign lv_sat  = (in_data_i.priority_req > 3'(LevelsUsed - 1)) ?
                   3'(LevelsUsed - 1) : in_data_i.priority_req;
  assign lv_idx  = LW'(lv_sat);
  assign run_idx = LW'(run_lvl_q);
  assign cur_idx = LW'(cur_lvl_q);
  assign higher  = (lv_sat < run_lvl_q);
  assign enq_full = full_q[lv_idx] || (higher && full_q[run_idx]);

  // First non-empty level at or below the configured start level.
  always_comb begin
    scan_found = 1'b0;
    scan_lvl   = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < LevelsUsed) begin
        if (!scan_found && (3'(i) >= search_start_q) && nonempty_q[LW'(i)]) begin
          scan_found = 1'b1;
          scan_lvl   = 3'(i);
        end
      end
    end
  end

  always_comb begin
    if (in_data_i.op == prq_pkg::OP_ENQUEUE) begin
      tgt_lvl    = lv_sat;
      acc_status = enq_full ? prq_pkg::STAT_FULL : prq_pkg::STAT_OK;
    end else begin
      tgt_lvl    = scan_lvl;
      acc_status = scan_found ? prq_pkg::STAT_OK : prq_pkg::STAT_EMPTY;
    end
  end

  assign tgt_idx = LW'(tgt_lvl);

  assign head_a = vld_a_q ? rd_a_q[2*PW-1:PW] : '0;
  assign tail_a = vld_a_q ? rd_a_q[PW-1:0]    : '0;
  assign head_b = vld_b_q ? rd_b_q[2*PW-1:PW] : '0;
  assign tail_b = vld_b_q ? rd_b_q[PW-1:0]    : '0;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      prq_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (acc_status == prq_pkg::STAT_OK) ? prq_pkg::ST_UPDATE : prq_pkg::ST_DONE;
        end
      end
      prq_pkg::ST_UPDATE: begin
        if (cur_op_q == prq_pkg::OP_SWITCH) begin
          state_d = prq_pkg::ST_POP;
        end else if (higher_q) begin
          state_d = prq_pkg::ST_PUSH_RUN;
        end else begin
          state_d = prq_pkg::ST_DONE;
        end
      end
      prq_pkg::ST_PUSH_RUN: state_d = prq_pkg::ST_DONE;
      prq_pkg::ST_POP:      state_d = prq_pkg::ST_DONE;
      prq_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = prq_pkg::ST_IDLE;
        end
      end
      default: state_d = prq_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ptr_we    = 1'b0;
    ptr_waddr = cur_idx;
    ptr_wdata = '0;
    flag_ne   = 1'b0;
    flag_full = 1'b0;
    st_we     = 1'b0;
    st_re     = 1'b0;
    st_addr   = '0;
    st_wdata  = cur_id_q;
    out_load  = 1'b0;
    case (state_q)
      prq_pkg::ST_UPDATE: begin
        ptr_we = 1'b1;
        if (cur_op_q == prq_pkg::OP_SWITCH) begin
          st_re     = 1'b1;
          st_addr   = entry_addr(cur_idx, head_a);
          ptr_wdata = {ptr_inc(head_a), tail_a};
          flag_ne   = (ptr_inc(head_a) != tail_a);
          flag_full = 1'b0;
        end else begin
          st_we     = 1'b1;
          st_addr   = entry_addr(cur_idx, tail_a);
          ptr_wdata = {head_a, ptr_inc(tail_a)};
          flag_ne   = 1'b1;
          flag_full = (ptr_inc(tail_a) == head_a);
        end
      end
      prq_pkg::ST_PUSH_RUN: begin
        // The displaced task goes back onto its own level.
        ptr_we    = 1'b1;
        ptr_waddr = run_idx;
        st_we     = 1'b1;
        st_addr   = entry_addr(run_idx, tail_b);
        st_wdata  = run_task_q;
        ptr_wdata = {head_b, ptr_inc(tail_b)};
        flag_ne   = 1'b1;
        flag_full = (ptr_inc(tail_b) == head_b);
      end
      prq_pkg::ST_DONE: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
      end
    endcase
  end

  prq_entry_ram #(
    .RAM_DEPTH(RamDepth)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .re_i   (st_re),
    .addr_i (st_addr),
    .wdata_i(st_wdata),
    .rdata_o(st_rdata)
  );

  // Pointer memory: head and tail per level, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (ptr_we) begin
      ptr_mem[ptr_waddr] <= ptr_wdata;
    end
    if (in_acc) begin
      rd_a_q <= ptr_mem[tgt_idx];
      rd_b_q <= ptr_mem[run_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_op_q  <= in_data_i.op;
      cur_lvl_q <= tgt_lvl;
      cur_id_q  <= in_data_i.task_id;
      higher_q  <= higher;
    end
    if (out_load) begin
      out_data_q.run_task     <= run_task_q;
      out_data_q.run_priority <= run_lvl_q;
      out_data_q.preempt      <= (status_q == prq_pkg::STAT_OK) &&
                                 (cur_op_q == prq_pkg::OP_ENQUEUE) && higher_q;
      out_data_q.status       <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= prq_pkg::ST_IDLE;
      search_start_q <= '0;
      run_task_q     <= '0;
      run_lvl_q      <= 3'(LevelsUsed - 1);
      status_q       <= prq_pkg::STAT_OK;
      nonempty_q     <= '0;
      full_q         <= '0;
      ptr_vld_q      <= '0;
      vld_a_q        <= 1'b0;
      vld_b_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        search_start_q <= cfg_data_i;
      end
      if (in_acc) begin
        status_q <= acc_status;
        vld_a_q  <= ptr_vld_q[tgt_idx];
        vld_b_q  <= ptr_vld_q[run_idx];
      end
      if (ptr_we) begin
        ptr_vld_q[ptr_waddr]  <= 1'b1;
        nonempty_q[ptr_waddr] <= flag_ne;
        full_q[ptr_waddr]     <= flag_full;
      end
      if (state_q == prq_pkg::ST_POP) begin
        run_task_q <= st_rdata;
        run_lvl_q  <= cur_lvl_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> src/prq_checker.sv
// Port-level checks for the priority ready queue scheduler, bound to the top level.
module prq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input prq_pkg::prq_out_t out_data_o
);

  // A result that is stalled is not withdrawn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // The block works on one word at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while one is in work");

  // A preemption is only reported on a successful enqueue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.preempt |-> out_data_o.status == prq_pkg::STAT_OK)
    else $error("preempt reported with a fault status");

  // A displaced task cannot have been running at the highest level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.preempt |-> out_data_o.run_priority != 3'd0)
    else $error("preempt reported for a highest-level task");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == prq_pkg::STAT_OK) ||
                    (out_data_o.status == prq_pkg::STAT_FULL) ||
                    (out_data_o.status == prq_pkg::STAT_EMPTY))
    else $error("undefined status code");

endmodule

bind priority_ready_queue_scheduler prq_checker u_prq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
